### rtl/afl_pkg.sv
// shared types and constants of the area portal flood labeler
// used by the controller, the datapath and the top level
package afl_pkg;

  localparam int AIDX_W  = 8;
  localparam int FIRST_W = 10;
  localparam int CNT_W   = 11;
  localparam int LIDX_W  = 10;
  localparam int PID_W   = 10;
  localparam int LABEL_W = 8;
  localparam int STAMP_W = 16;
  localparam int ACFG_W  = 9;

  typedef enum logic [2:0] {
    CMD_WRITE_AREA = 3'd0,
    CMD_WRITE_LINK = 3'd1,
    CMD_SET_PORTAL = 3'd2,
    CMD_CLOSE_ALL  = 3'd3,
    CMD_FLOOD      = 3'd4,
    CMD_READ_LABEL = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CLOSE,
    S_GEN,
    S_SCAN,
    S_SCAN_W,
    S_REC_W,
    S_LINK,
    S_LINK_W,
    S_PORT_W,
    S_NB_W,
    S_POP_W,
    S_READ_W,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic wr_area;
    logic wr_link;
    logic wr_portal;
    logic clr_start;
    logic clr_all;
    logic clr_portal;
    logic rd_label;
    logic take_label;
    logic gen_bump;
    logic scan_skip;
    logic scan_start;
    logic rec_take;
    logic link_rd;
    logic link_take;
    logic nb_rd;
    logic nb_mark;
    logic push;
    logic pop_rd;
    logic pop_take;
    logic abort;
    logic res_load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       clr_last;
    logic       close_last;
    logic       scan_end;
    logic       stamp_hit;
    logic       label_same;
    logic       pos_end;
    logic       depth_one;
    logic       depth_room;
    logic       portal_open;
  } st_t;

endpackage

### rtl/area_portal_flood_labeler.sv
// top level of the area portal flood labeler
// depends on afl_pkg, afl_ctrl, afl_dpath
//
// one command transaction in, one result transaction out, valid/stall on both
// channels. a command is taken when in_valid is high and in_stall is low;
// in_stall is high from the accept until the result is loaded into the
// output register, so one command is in flight at a time. a held result
// does not block the next command.
// a close all sweeps every portal bit before it gives its result; a flood
// scans the start areas and walks each group from them, paced by the single
// read port of each table (one access per step of the walk).
// cfg_write loads area_count at once; write it only while idle.
// after rst the block clears the label/stamp table and the portal bits,
// holding in_stall high until both are cleared.
// a stalled result holds its value until out_stall falls.
// table depths are powers of two; indices are folded into them.
module area_portal_flood_labeler #(
  parameter int MAX_AREAS   = 256,
  parameter int MAX_PORTALS = 1024,
  parameter int LINK_DEPTH  = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [afl_pkg::ACFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  command,
  input  logic [afl_pkg::AIDX_W-1:0]  area_index,
  input  logic [afl_pkg::FIRST_W-1:0] first_link,
  input  logic [afl_pkg::CNT_W-1:0]   link_count,
  input  logic [afl_pkg::LIDX_W-1:0]  link_index,
  input  logic [afl_pkg::PID_W-1:0]   portal_id,
  input  logic [afl_pkg::AIDX_W-1:0]  neighbor_area,
  input  logic                        open_flag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [afl_pkg::LABEL_W-1:0] label,
  output logic [afl_pkg::LABEL_W-1:0] group_count,
  output logic                        reflooded
);
  import afl_pkg::*;

  ctl_t ctl;
  st_t  st;

  afl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .ctl(ctl)
  );

  afl_dpath #(
    .MAX_AREAS(MAX_AREAS), .MAX_PORTALS(MAX_PORTALS), .LINK_DEPTH(LINK_DEPTH)
  ) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .st(st),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .command(command), .area_index(area_index), .first_link(first_link),
    .link_count(link_count), .link_index(link_index), .portal_id(portal_id),
    .neighbor_area(neighbor_area), .open_flag(open_flag),
    .label(label), .group_count(group_count), .reflooded(reflooded)
  );

endmodule

### rtl/afl_ram.sv
// generic single write port ram with registered read
// no dependencies
module afl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/afl_ctrl.sv
// controller state machine of the flood labeler
// depends on afl_pkg; drives datapath strobes, reads datapath status
module afl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  afl_pkg::st_t  st,
  output afl_pkg::ctl_t ctl
);
  import afl_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (st.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          priority case (st.cmd)
            CMD_CLOSE_ALL:  state_next = S_CLOSE;
            CMD_FLOOD:      state_next = S_GEN;
            CMD_READ_LABEL: state_next = S_READ_W;
            default:        state_next = S_DONE;
          endcase
        end
      end
      S_CLOSE:  if (st.close_last) state_next = S_DONE;
      S_GEN:    state_next = S_SCAN;
      S_SCAN:   state_next = st.scan_end ? S_DONE : S_SCAN_W;
      S_SCAN_W: state_next = st.stamp_hit ? S_SCAN : S_REC_W;
      S_REC_W:  state_next = S_LINK;
      S_LINK: begin
        if (!st.pos_end) state_next = S_LINK_W;
        else if (st.depth_one) state_next = S_SCAN;
        else state_next = S_POP_W;
      end
      S_LINK_W: state_next = S_PORT_W;
      S_PORT_W: state_next = st.portal_open ? S_NB_W : S_LINK;
      S_NB_W: begin
        if (st.stamp_hit) state_next = st.label_same ? S_LINK : S_DONE;
        else state_next = st.depth_room ? S_REC_W : S_LINK;
      end
      S_POP_W:  state_next = S_REC_W;
      S_READ_W: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      S_CLEAR: ctl.clr_all = 1'b1;
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          priority case (st.cmd)
            CMD_WRITE_AREA: ctl.wr_area   = 1'b1;
            CMD_WRITE_LINK: ctl.wr_link   = 1'b1;
            CMD_SET_PORTAL: ctl.wr_portal = 1'b1;
            CMD_CLOSE_ALL:  ctl.clr_start = 1'b1;
            CMD_READ_LABEL: ctl.rd_label  = 1'b1;
            default: ;
          endcase
        end
      end
      S_CLOSE:  ctl.clr_portal = 1'b1;
      S_GEN:    ctl.gen_bump   = 1'b1;
      S_SCAN_W: begin
        ctl.scan_skip  = st.stamp_hit;
        ctl.scan_start = !st.stamp_hit;
      end
      S_REC_W:  ctl.rec_take = 1'b1;
      S_LINK: begin
        ctl.link_rd   = !st.pos_end;
        ctl.scan_skip = st.pos_end && st.depth_one;
        ctl.pop_rd    = st.pos_end && !st.depth_one;
      end
      S_LINK_W: ctl.link_take = 1'b1;
      S_PORT_W: ctl.nb_rd     = st.portal_open;
      S_NB_W: begin
        ctl.abort   = st.stamp_hit && !st.label_same;
        ctl.nb_mark = !st.stamp_hit;
        ctl.push    = !st.stamp_hit && st.depth_room;
      end
      S_POP_W:  ctl.pop_take   = 1'b1;
      S_READ_W: ctl.take_label = 1'b1;
      S_DONE:   ctl.res_load   = out_free;
      default: ;
    endcase
  end

endmodule

### rtl/afl_dpath.sv
// datapath of the flood labeler: tables, walk stack, counters, result registers
// depends on afl_pkg and afl_ram
module afl_dpath #(
  parameter int MAX_AREAS   = 256,
  parameter int MAX_PORTALS = 1024,
  parameter int LINK_DEPTH  = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  afl_pkg::ctl_t                 ctl,
  output afl_pkg::st_t                  st,
  input  logic                          cfg_write,
  input  logic [afl_pkg::ACFG_W-1:0]    cfg_data,
  input  logic [2:0]                    command,
  input  logic [afl_pkg::AIDX_W-1:0]    area_index,
  input  logic [afl_pkg::FIRST_W-1:0]   first_link,
  input  logic [afl_pkg::CNT_W-1:0]     link_count,
  input  logic [afl_pkg::LIDX_W-1:0]    link_index,
  input  logic [afl_pkg::PID_W-1:0]     portal_id,
  input  logic [afl_pkg::AIDX_W-1:0]    neighbor_area,
  input  logic                          open_flag,
  output logic [afl_pkg::LABEL_W-1:0]   label,
  output logic [afl_pkg::LABEL_W-1:0]   group_count,
  output logic                          reflooded
);
  import afl_pkg::*;

  localparam int AW  = $clog2(MAX_AREAS);
  localparam int PW  = $clog2(MAX_PORTALS);
  localparam int LW  = $clog2(LINK_DEPTH);
  localparam int CW  = (AW + 1 > ACFG_W) ? AW + 1 : ACFG_W;
  localparam int SWP = (MAX_AREAS > MAX_PORTALS) ? MAX_AREAS : MAX_PORTALS;
  localparam int SW  = $clog2(SWP);
  localparam int LSW = LABEL_W + STAMP_W;
  localparam int ARW = FIRST_W + CNT_W;
  localparam int LKW = PID_W + AIDX_W;
  localparam int SKW = AW + CNT_W;

  logic [ACFG_W-1:0]  area_cfg;
  logic [STAMP_W-1:0] gen, gen_inc;
  logic [CW-1:0]      scan_i, limit, acnt_ext, max_ext;
  logic [LABEL_W-1:0] groups, groups_inc, res_label;
  logic               res_reflood;
  logic [AW:0]        depth, depth_m1, depth_m2;
  logic [AW-1:0]      cur_area;
  logic [CNT_W-1:0]   cur_pos, cur_cnt;
  logic [FIRST_W-1:0] cur_first;
  logic [AIDX_W-1:0]  nb_reg;
  logic [SW-1:0]      sweep;

  logic [AW+AIDX_W-1:0] ai_ext, nb_ext;
  logic [PW+PID_W-1:0]  pid_ext, lpid_ext;
  logic [LW+LIDX_W-1:0] li_ext;
  logic [CNT_W:0]       lsum;
  logic [LW+CNT_W:0]    lsum_ext;
  logic [AW+SW-1:0]     swa_ext;
  logic [PW+SW-1:0]     swp_ext;
  logic [AW-1:0]        ai, nb, sw_area;
  logic [PW-1:0]        pid_w, sw_port, lpid;
  logic [LW-1:0]        li_w, ladr;

  logic           ls_we, ar_we, lk_we, pt_we, sk_we;
  logic [AW-1:0]  ls_waddr, ls_raddr, ar_waddr, ar_raddr;
  logic [LSW-1:0] ls_wdata, ls_rdata;
  logic [ARW-1:0] ar_rdata;
  logic [LKW-1:0] lk_rdata;
  logic [PW-1:0]  pt_waddr;
  logic           pt_wdata, pt_rdata;
  logic [SKW-1:0] sk_rdata;

  // index folding into table depths
  assign ai_ext   = {{AW{1'b0}}, area_index};
  assign ai       = ai_ext[AW-1:0];
  assign nb_ext   = {{AW{1'b0}}, nb_reg};
  assign nb       = nb_ext[AW-1:0];
  assign pid_ext  = {{PW{1'b0}}, portal_id};
  assign pid_w    = pid_ext[PW-1:0];
  assign lpid_ext = {{PW{1'b0}}, lk_rdata[LKW-1:AIDX_W]};
  assign lpid     = lpid_ext[PW-1:0];
  assign li_ext   = {{LW{1'b0}}, link_index};
  assign li_w     = li_ext[LW-1:0];
  assign lsum     = {1'b0, cur_pos} + {{(CNT_W + 1 - FIRST_W){1'b0}}, cur_first};
  assign lsum_ext = {{LW{1'b0}}, lsum};
  assign ladr     = lsum_ext[LW-1:0];
  assign swa_ext  = {{AW{1'b0}}, sweep};
  assign sw_area  = swa_ext[AW-1:0];
  assign swp_ext  = {{PW{1'b0}}, sweep};
  assign sw_port  = swp_ext[PW-1:0];

  assign acnt_ext = CW'(area_cfg);
  assign max_ext  = CW'(MAX_AREAS);
  assign limit    = (acnt_ext > max_ext) ? max_ext : acnt_ext;
  assign gen_inc  = (gen == {STAMP_W{1'b1}}) ? STAMP_W'(1) : gen + STAMP_W'(1);
  assign groups_inc = groups + LABEL_W'(1);
  assign depth_m1 = depth - (AW + 1)'(1);
  assign depth_m2 = depth - (AW + 1)'(2);

  assign st.cmd         = command;
  assign st.clr_last    = (sweep == SW'(SWP - 1));
  assign st.close_last  = (sweep == SW'(MAX_PORTALS - 1));
  assign st.scan_end    = (scan_i >= limit);
  assign st.stamp_hit   = (ls_rdata[STAMP_W-1:0] == gen);
  assign st.label_same  = (ls_rdata[LSW-1:STAMP_W] == groups);
  assign st.pos_end     = (cur_pos >= cur_cnt);
  assign st.depth_one   = (depth == (AW + 1)'(1));
  assign st.depth_room  = (depth < (AW + 1)'(MAX_AREAS));
  assign st.portal_open = pt_rdata;

  // label and stamp table ports
  always_comb begin
    ls_we    = 1'b0;
    ls_waddr = ai;
    ls_wdata = '0;
    priority if (ctl.clr_all) begin
      ls_we    = ({{(CW - SW > 0 ? CW - SW : 1){1'b0}}, sweep} < (CW + SW)'(MAX_AREAS));
      ls_waddr = sw_area;
    end else if (ctl.wr_area) begin
      ls_we = 1'b1;
    end else if (ctl.scan_start) begin
      ls_we    = 1'b1;
      ls_waddr = scan_i[AW-1:0];
      ls_wdata = {groups_inc, gen};
    end else if (ctl.nb_mark) begin
      ls_we    = 1'b1;
      ls_waddr = nb;
      ls_wdata = {groups, gen};
    end else begin
      ls_we = 1'b0;
    end
  end

  always_comb begin
    priority if (ctl.rd_label) ls_raddr = ai;
    else if (ctl.nb_rd) ls_raddr = nb;
    else ls_raddr = scan_i[AW-1:0];
  end

  // area record ports
  assign ar_we    = ctl.wr_area;
  assign ar_waddr = ai;
  always_comb begin
    priority if (ctl.push) ar_raddr = nb;
    else if (ctl.pop_take) ar_raddr = sk_rdata[SKW-1:CNT_W];
    else ar_raddr = scan_i[AW-1:0];
  end

  // portal open bits
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = pid_w;
    pt_wdata = open_flag;
    priority if (ctl.clr_all || ctl.clr_portal) begin
      pt_we    = ({{(PW > SW ? PW - SW : 1){1'b0}}, sweep} < (SW + PW)'(MAX_PORTALS));
      pt_waddr = sw_port;
      pt_wdata = 1'b0;
    end else if (ctl.wr_portal) begin
      pt_we = 1'b1;
    end else begin
      pt_we = 1'b0;
    end
  end

  assign lk_we = ctl.wr_link;
  assign sk_we = ctl.push;

  afl_ram #(.WIDTH(LSW), .DEPTH(MAX_AREAS)) u_label_ram (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(ls_raddr), .rdata(ls_rdata)
  );

  afl_ram #(.WIDTH(ARW), .DEPTH(MAX_AREAS)) u_area_ram (
    .clk(clk), .we(ar_we), .waddr(ar_waddr), .wdata({first_link, link_count}),
    .raddr(ar_raddr), .rdata(ar_rdata)
  );

  afl_ram #(.WIDTH(LKW), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk(clk), .we(lk_we), .waddr(li_w), .wdata({portal_id, neighbor_area}),
    .raddr(ladr), .rdata(lk_rdata)
  );

  afl_ram #(.WIDTH(1), .DEPTH(MAX_PORTALS)) u_portal_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(lpid), .rdata(pt_rdata)
  );

  afl_ram #(.WIDTH(SKW), .DEPTH(MAX_AREAS)) u_stack_ram (
    .clk(clk), .we(sk_we), .waddr(depth_m1[AW-1:0]), .wdata({cur_area, cur_pos}),
    .raddr(depth_m2[AW-1:0]), .rdata(sk_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      area_cfg <= ACFG_W'(1);
      gen      <= '0;
      sweep    <= '0;
    end else begin
      if (cfg_write) begin
        area_cfg <= cfg_data;
      end
      if (ctl.gen_bump) begin
        gen <= gen_inc;
      end
      if (ctl.clr_start) begin
        sweep <= '0;
      end else if (ctl.clr_all || ctl.clr_portal) begin
        sweep <= sweep + SW'(1);
      end
    end
  end

  // walk registers and result staging
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      groups      <= '0;
      res_label   <= '0;
      res_reflood <= 1'b0;
    end
    if (ctl.take_label) res_label <= ls_rdata[LSW-1:STAMP_W];
    if (ctl.abort) res_reflood <= 1'b1;
    if (ctl.gen_bump) scan_i <= CW'(1);
    if (ctl.scan_skip) scan_i <= scan_i + CW'(1);
    if (ctl.scan_start) begin
      groups   <= groups_inc;
      cur_area <= scan_i[AW-1:0];
      cur_pos  <= '0;
      depth    <= (AW + 1)'(1);
    end
    if (ctl.rec_take) begin
      cur_first <= ar_rdata[ARW-1:CNT_W];
      cur_cnt   <= ar_rdata[CNT_W-1:0];
    end
    if (ctl.link_rd) cur_pos <= cur_pos + CNT_W'(1);
    if (ctl.link_take) nb_reg <= lk_rdata[AIDX_W-1:0];
    if (ctl.push) begin
      cur_area <= nb;
      cur_pos  <= '0;
      depth    <= depth + (AW + 1)'(1);
    end
    if (ctl.pop_rd) depth <= depth_m1;
    if (ctl.pop_take) begin
      cur_area <= sk_rdata[SKW-1:CNT_W];
      cur_pos  <= sk_rdata[CNT_W-1:0];
    end
    if (ctl.res_load) begin
      label       <= res_label;
      group_count <= groups;
      reflooded   <= res_reflood;
    end
  end

endmodule

### rtl/afl_checker.sv
// port level checks of the flood labeler, bound to the top level
// depends on afl_pkg and area_portal_flood_labeler
module afl_port_checks (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [afl_pkg::LABEL_W-1:0] label,
  input logic [afl_pkg::LABEL_W-1:0] group_count,
  input logic                        reflooded
);
  import afl_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("command accepted while previous one in flight");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(label)
      && $stable(group_count) && $stable(reflooded)))
    else $error("stalled result changed");

  // flood results carry no label
  a_flood_no_label: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (reflooded || group_count != '0)) |-> (label == '0))
    else $error("flood result with nonzero label");

endmodule

bind area_portal_flood_labeler afl_port_checks u_afl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .label(label),
  .group_count(group_count), .reflooded(reflooded)
);

### verif/afl_checker.sv
// checker for the area portal flood labeler: predicts every result from the
// observed command and configuration transactions and compares field by field
// depends on afl_pkg
module afl_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [afl_pkg::ACFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [2:0]                  command,
  input  logic [afl_pkg::AIDX_W-1:0]  area_index,
  input  logic [afl_pkg::FIRST_W-1:0] first_link,
  input  logic [afl_pkg::CNT_W-1:0]   link_count,
  input  logic [afl_pkg::LIDX_W-1:0]  link_index,
  input  logic [afl_pkg::PID_W-1:0]   portal_id,
  input  logic [afl_pkg::AIDX_W-1:0]  neighbor_area,
  input  logic                        open_flag,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [afl_pkg::LABEL_W-1:0] label,
  input  logic [afl_pkg::LABEL_W-1:0] group_count,
  input  logic                        reflooded,
  output int                          fails,
  output int                          pending
);
  import afl_pkg::*;

  typedef struct {
    logic [7:0] lab;
    logic [7:0] groups;
    logic       refl;
  } result_t;

  result_t    result_q[$];
  logic [9:0]  first_mem[256];
  logic [10:0] cnt_mem[256];
  logic [7:0]  lab_mem[256];
  logic [15:0] stamp_mem[256];
  logic [9:0]  lport_mem[1024];
  logic [7:0]  lnb_mem[1024];
  logic        open_mem[1024];
  logic [15:0] gen;
  logic [8:0]  area_cnt;

  task automatic predict_flood(output logic [7:0] groups, output logic conflict);
    int lim, depth;
    logic [7:0]  st_area[256];
    logic [10:0] st_pos[256];
    logic [7:0]  a, n;
    logic [9:0]  li;
    groups = 0;
    conflict = 0;
    lim = (area_cnt > 256) ? 256 : area_cnt;
    gen = gen + 16'd1;
    if (gen == 0) gen = 16'd1;
    for (int i = 1; i < lim && !conflict; i++) begin
      if (stamp_mem[i] == gen) continue;
      groups = groups + 8'd1;
      stamp_mem[i] = gen;
      lab_mem[i] = groups;
      st_area[0] = i[7:0];
      st_pos[0] = 0;
      depth = 1;
      while (depth > 0 && !conflict) begin
        a = st_area[depth-1];
        if (st_pos[depth-1] >= cnt_mem[a]) begin
          depth--;
          continue;
        end
        li = first_mem[a] + st_pos[depth-1][9:0];
        st_pos[depth-1] = st_pos[depth-1] + 11'd1;
        if (!open_mem[lport_mem[li]]) continue;
        n = lnb_mem[li];
        if (stamp_mem[n] == gen) begin
          if (lab_mem[n] != groups) conflict = 1;
          continue;
        end
        stamp_mem[n] = gen;
        lab_mem[n] = groups;
        if (depth < 256) begin
          st_area[depth] = n;
          st_pos[depth] = 0;
          depth++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      for (int i = 0; i < 256; i++) begin
        first_mem[i] = 0;
        cnt_mem[i] = 0;
        lab_mem[i] = 0;
        stamp_mem[i] = 0;
      end
      for (int i = 0; i < 1024; i++) begin
        lport_mem[i] = 0;
        lnb_mem[i] = 0;
        open_mem[i] = 0;
      end
      gen = 0;
      area_cnt = 9'd1;
      result_q.delete();
      fails = 0;
    end else begin
      if (cfg_write) area_cnt = cfg_data;
      if (out_valid && !out_stall) begin
        got = '{label, group_count, reflooded};
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: label %0d groups %0d reflooded %0b",
                     label, group_count, reflooded);
        end else begin
          want = result_q.pop_front();
          if (got.lab !== want.lab || got.groups !== want.groups ||
              got.refl !== want.refl) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected label %0d groups %0d reflooded %0b, got %0d %0d %0b",
                       want.lab, want.groups, want.refl, got.lab, got.groups, got.refl);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = '{8'd0, 8'd0, 1'b0};
        case (command)
          CMD_WRITE_AREA: begin
            first_mem[area_index] = first_link;
            cnt_mem[area_index] = link_count;
            lab_mem[area_index] = 0;
            stamp_mem[area_index] = 0;
          end
          CMD_WRITE_LINK: begin
            lport_mem[link_index] = portal_id;
            lnb_mem[link_index] = neighbor_area;
          end
          CMD_SET_PORTAL: open_mem[portal_id] = open_flag;
          CMD_CLOSE_ALL: for (int i = 0; i < 1024; i++) open_mem[i] = 0;
          CMD_FLOOD: predict_flood(want.groups, want.refl);
          CMD_READ_LABEL: want.lab = lab_mem[area_index];
          default: ;
        endcase
        result_q.push_back(want);
      end
    end
    pending = result_q.size();
  end
endmodule

### verif/tb_area_portal_flood_labeler.sv
// top of the area portal flood labeler testbench: clock, reset, command and
// configuration stimulus, output stall pattern and the verdict
// depends on afl_pkg, area_portal_flood_labeler and afl_checker
module tb_area_portal_flood_labeler;
  import afl_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int PHASE_OPS = 3;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [ACFG_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [2:0]          command;
  logic [AIDX_W-1:0]   area_index;
  logic [FIRST_W-1:0]  first_link;
  logic [CNT_W-1:0]    link_count;
  logic [LIDX_W-1:0]   link_index;
  logic [PID_W-1:0]    portal_id;
  logic [AIDX_W-1:0]   neighbor_area;
  logic                open_flag;
  logic                out_valid;
  logic                out_stall;
  logic [LABEL_W-1:0]  label;
  logic [LABEL_W-1:0]  group_count;
  logic                reflooded;
  int                  fails;
  int                  pending;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  bit                  hold_req;
  int                  cur_areas;

  area_portal_flood_labeler dut (.*);
  afl_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

  // output side: random stall, or a long counted hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 600;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic put_cmd(logic [2:0] c, logic [7:0] ai, logic [9:0] fl, logic [10:0] lc,
                         logic [9:0] li, logic [9:0] pid, logic [7:0] nb, logic op);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1;
    command <= c;
    area_index <= ai;
    first_link <= fl;
    link_count <= lc;
    link_index <= li;
    portal_id <= pid;
    neighbor_area <= nb;
    open_flag <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // area record whose link run lies in the written window 1022..1023, 0..5
  task automatic write_area_safe(logic [7:0] ai);
    int s, len;
    s = $urandom_range(0, 7) - 2;
    len = $urandom_range(0, (6 - s) < 4 ? (6 - s) : 4);
    if ($urandom_range(0, 9) == 0) begin
      put_cmd(CMD_WRITE_AREA, ai, $urandom, 11'd0, $urandom, $urandom, $urandom, $urandom);
    end else begin
      put_cmd(CMD_WRITE_AREA, ai, s[9:0], len[10:0], $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic write_window_link(int idx);
    logic [7:0] nb;
    nb = ($urandom_range(0, 3) == 0 || cur_areas < 2) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, cur_areas - 1);
    put_cmd(CMD_WRITE_LINK, $urandom, $urandom, $urandom, idx[9:0],
            $urandom_range(0, 15), nb, $urandom);
  endtask

  task automatic random_op();
    int r, w;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      write_area_safe($urandom_range(0, 255));
    end else if (r < 45) begin
      if ($urandom_range(0, 9) < 6) begin
        w = $urandom_range(0, 7) - 2;
        write_window_link(w < 0 ? w + 1024 : w);
      end else begin
        put_cmd(CMD_WRITE_LINK, $urandom, $urandom, $urandom, $urandom_range(6, 1021),
                $urandom, $urandom, $urandom);
      end
    end else if (r < 65) begin
      put_cmd(CMD_SET_PORTAL, $urandom, $urandom, $urandom, $urandom,
              ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15),
              $urandom, ($urandom_range(0, 3) != 0));
    end else if (r < 68) begin
      put_cmd(CMD_CLOSE_ALL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
    end else if (r < 80) begin
      put_cmd(CMD_FLOOD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
    end else if (r < 97) begin
      put_cmd(CMD_READ_LABEL,
              ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : $urandom_range(0, 15),
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      put_cmd(($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_areas(logic [8:0] v);
    cfg_write <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 0;
    @(negedge clk);
    cur_areas = (v > 256) ? 256 : v;
  endtask

  initial begin
    logic [8:0] cfg_vals[9];
    cfg_vals = '{9'd0, 9'd2, 9'd9, 9'd511, 9'd17, 9'd256, 9'd5, 9'd30, 9'd255};
    rst = 1;
    cfg_write = 0;
    cfg_data = 0;
    in_valid = 0;
    command = 0;
    area_index = 0;
    first_link = 0;
    link_count = 0;
    link_index = 0;
    portal_id = 0;
    neighbor_area = 0;
    open_flag = 0;
    hold_req = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_areas = 1;
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    while (in_stall) @(negedge clk);

    // directed: extremes with area_count at its reset value
    put_cmd(CMD_FLOOD, 0, 0, 0, 0, 0, 0, 0);
    put_cmd(CMD_READ_LABEL, 8'd255, 0, 0, 0, 0, 0, 0);
    put_cmd(CMD_READ_LABEL, 8'd0, 0, 0, 0, 0, 0, 0);
    put_cmd(CMD_SPARE_A, 8'hff, 10'h3ff, 11'h7ff, 10'h3ff, 10'h3ff, 8'hff, 1);
    put_cmd(CMD_SPARE_B, 0, 0, 0, 0, 0, 0, 0);
    put_cmd(CMD_WRITE_AREA, 8'd255, 10'd1023, 11'd1024, 0, 0, 0, 0);
    put_cmd(CMD_SET_PORTAL, 0, 0, 0, 0, 10'd1023, 0, 1);
    put_cmd(CMD_SET_PORTAL, 0, 0, 0, 0, 10'd0, 0, 1);
    put_cmd(CMD_CLOSE_ALL, 0, 0, 0, 0, 0, 0, 0);

    // every area record and the link window are written before any real flood
    cur_areas = 16;
    for (int i = 1022; i < 1024; i++) write_window_link(i);
    for (int i = 0; i < 6; i++) write_window_link(i);
    put_cmd(CMD_WRITE_LINK, 0, 0, 0, 10'd1023, 10'd1023, 8'd255, 0);
    put_cmd(CMD_WRITE_LINK, 0, 0, 0, 10'd0, 10'd0, 8'd0, 0);
    for (int i = 0; i < 256; i++) write_area_safe(i);
    put_cmd(CMD_WRITE_AREA, 8'd3, 10'd1022, 11'd4, 0, 0, 0, 0);
    for (int p = 0; p < 4; p++) put_cmd(CMD_SET_PORTAL, 0, 0, 0, 0, p, 0, 1);
    drain();
    set_areas(9'd16);
    put_cmd(CMD_FLOOD, 0, 0, 0, 0, 0, 0, 0);
    put_cmd(CMD_READ_LABEL, 8'd3, 0, 0, 0, 0, 0, 0);
    put_cmd(CMD_WRITE_AREA, 8'd3, 10'd0, 11'd0, 0, 0, 0, 0);
    put_cmd(CMD_READ_LABEL, 8'd3, 0, 0, 0, 0, 0, 0);
    put_cmd(CMD_FLOOD, 0, 0, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      set_areas(cfg_vals[ph]);
      send_idle_pct = (ph < 3) ? 22 : (ph < 6) ? 80 : 0;
      recv_idle_pct = (ph < 3) ? 80 : (ph < 6) ? 22 : 0;
      for (int k = 0; k < PHASE_OPS; k++) begin
        if (ph == 1 && k == 0) hold_req = 1;
        if (ph == 4 && k == 1) drain();
        if (k == PHASE_OPS - 1) begin
          put_cmd(CMD_FLOOD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
        end else begin
          random_op();
        end
      end
    end
    drain();
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### area_portal_flood_labeler.f
rtl/afl_pkg.sv
rtl/afl_ram.sv
rtl/afl_ctrl.sv
rtl/afl_dpath.sv
rtl/area_portal_flood_labeler.sv
rtl/afl_checker.sv
verif/afl_checker.sv
verif/tb_area_portal_flood_labeler.sv
